### sv/rrd_pkg.sv
`timescale 1ns / 1ps
package rrd_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int COUNT_BITS    = 16;
	localparam int RUN_BITS      = 4;
	localparam int IDLE_BITS     = 8;
	localparam int RATE_BITS     = 13;
	localparam int BPM_BITS      = 10;
	localparam int TREND_BITS    = 4;
	localparam int HZ_BITS       = 7;
	localparam int TICK_BITS     = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 10;
	localparam int PROD_BITS     = BPM_BITS + COUNT_BITS;
	localparam int STEP_BITS     = 4;

	localparam logic [RUN_BITS-1:0]  RUN_MAX  = '1;
	localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_CW    = 3;

	localparam logic ACTION_SAMPLE = 1'b0;
	localparam logic ACTION_TICK   = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_BREATH_MIN     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BREATH_MAX     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TREND_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE_HZ = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT_TICKS  = 3'd4;

	typedef logic [1:0] op_t;
	localparam op_t OP_HOLD    = 2'd0;
	localparam op_t OP_BREATH  = 2'd1;
	localparam op_t OP_TIMEOUT = 2'd2;

	typedef struct packed {
		op_t                   op;
		logic [COUNT_BITS-1:0] n;
		logic                  active;
	} cmd_t;

	typedef struct packed {
		logic [BPM_BITS-1:0]   breath_min;
		logic [BPM_BITS-1:0]   breath_max;
		logic [TREND_BITS-1:0] trend_length;
		logic [HZ_BITS-1:0]    sample_rate_hz;
		logic [TICK_BITS-1:0]  timeout_ticks;
	} cfg_t;

endpackage

### sv/rrd_in_if.sv
`timescale 1ns / 1ps
interface rrd_in_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [rrd_pkg::SAMPLE_BITS-1:0] sample;

	modport source(output valid, action, sample, input ready);
	modport sink(input valid, action, sample, output ready);
endinterface

### sv/rrd_out_if.sv
`timescale 1ns / 1ps
interface rrd_out_if;
	logic                          valid;
	logic                          ready;
	logic                          breath_event;
	logic [rrd_pkg::RATE_BITS-1:0] rate_bpm;
	logic                          rate_alarm;
	logic                          breathing_active;

	modport source(output valid, breath_event, rate_bpm, rate_alarm, breathing_active,
		input ready);
	modport sink(input valid, breath_event, rate_bpm, rate_alarm, breathing_active,
		output ready);
endinterface

### sv/respiration_rate_detector.sv
`timescale 1ns / 1ps
// A non-breath transaction is written to the queue on acceptance and into the output
// register when the back end pops it while free; a breath with a nonzero sample count
// passes through pop, multiply, 13 restoring-divide steps and write-back in the back end.
// Throughput: one transaction per cycle into a 4-entry queue while it is not full; the
// back end drains one per cycle while out.ready is high, except breaths using the divider.
// Reset (arst_n low, asynchronous): control registers take their defaults, queue empties.
module respiration_rate_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	rrd_in_if.sink                            in,
	rrd_out_if.source                         out,
	input  logic                              cfg_we,
	input  logic [rrd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rrd_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

	// Configuration registers; user must write them only while the block is quiet (unenforced).
	rrd_pkg::cfg_t cfg_q;

	// Command queue between the classifier and the rate engine.
	rrd_pkg::cmd_t push_cmd, head_cmd;
	logic          push, pop, full, head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.breath_min     <= rrd_pkg::BPM_BITS'(5);
			cfg_q.breath_max     <= rrd_pkg::BPM_BITS'(100);
			cfg_q.trend_length   <= rrd_pkg::TREND_BITS'(5);
			cfg_q.sample_rate_hz <= rrd_pkg::HZ_BITS'(10);
			cfg_q.timeout_ticks  <= rrd_pkg::TICK_BITS'(5);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rrd_pkg::REG_BREATH_MIN:
					cfg_q.breath_min <= cfg_wdata[rrd_pkg::BPM_BITS-1:0];
				rrd_pkg::REG_BREATH_MAX:
					cfg_q.breath_max <= cfg_wdata[rrd_pkg::BPM_BITS-1:0];
				rrd_pkg::REG_TREND_LENGTH:
					cfg_q.trend_length <= cfg_wdata[rrd_pkg::TREND_BITS-1:0];
				rrd_pkg::REG_SAMPLE_RATE_HZ:
					cfg_q.sample_rate_hz <= cfg_wdata[rrd_pkg::HZ_BITS-1:0];
				rrd_pkg::REG_TIMEOUT_TICKS:
					cfg_q.timeout_ticks <= cfg_wdata[rrd_pkg::TICK_BITS-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// Front end: track the sample trend, phases, sample count and tick timeout;
	// classify each transaction as hold, breath or timeout.
	rrd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (in),
		.cfg        (cfg_q),
		.cmd        (push_cmd),
		.cmd_push   (push),
		.queue_full (full)
	);

	// Decouple the two halves so a long divide stalls sample intake only once the queue is full.
	rrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_cmd),
		.full       (full),
		.pop        (pop),
		.head       (head_cmd),
		.head_valid (head_valid)
	);

	// Back end: hold the current rate and alarm, run the serial divider on a breath
	// with a nonzero sample count, and present each result in the output register.
	rrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (head_cmd),
		.cmd_valid (head_valid),
		.cmd_pop   (pop),
		.out       (out)
	);

endmodule

### sv/rrd_queue.sv
`timescale 1ns / 1ps
module rrd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rrd_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output rrd_pkg::cmd_t head,
	output logic          head_valid
);

	rrd_pkg::cmd_t                   mem_q [rrd_pkg::QUEUE_DEPTH];
	logic [rrd_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [rrd_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [rrd_pkg::QUEUE_CW-1:0]    count_q;

	assign full       = (count_q == rrd_pkg::QUEUE_CW'(rrd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

### sv/rrd_front.sv
`timescale 1ns / 1ps
module rrd_front (
	input  logic          clk,
	input  logic          arst_n,
	rrd_in_if.sink        in,
	input  rrd_pkg::cfg_t cfg,
	output rrd_pkg::cmd_t cmd,
	output logic          cmd_push,
	input  logic          queue_full
);

	logic [rrd_pkg::SAMPLE_BITS-1:0] prev_q;
	logic [rrd_pkg::RUN_BITS-1:0]    rise_q, fall_q, rise_nx, fall_nx;
	logic                            falling_q, rising_q;
	logic [rrd_pkg::COUNT_BITS-1:0]  ssb_q, ssb_inc;
	logic [rrd_pkg::IDLE_BITS-1:0]   idle_q, idle_inc;
	logic                            active_q;
	logic                            is_breath, rearm, expire;

	assign in.ready = !queue_full;
	assign cmd_push = in.valid && in.ready;

	always_comb begin
		rise_nx = rise_q;
		fall_nx = fall_q;
		if (prev_q < in.sample) begin
			rise_nx = (rise_q == rrd_pkg::RUN_MAX) ? rise_q : rise_q + 1'b1;
			fall_nx = '0;
		end else if (prev_q > in.sample) begin
			fall_nx = (fall_q == rrd_pkg::RUN_MAX) ? fall_q : fall_q + 1'b1;
			rise_nx = '0;
		end
		is_breath = (rise_nx >= cfg.trend_length) && falling_q;
		rearm     = !is_breath && (fall_nx >= cfg.trend_length) && rising_q;
		ssb_inc   = (ssb_q == '1) ? ssb_q : ssb_q + 1'b1;
		idle_inc  = (idle_q == rrd_pkg::IDLE_MAX) ? idle_q : idle_q + 1'b1;
		expire    = (idle_inc >= cfg.timeout_ticks);

		cmd.n = ssb_q;
		if (in.action == rrd_pkg::ACTION_TICK) begin
			cmd.op     = expire ? rrd_pkg::OP_TIMEOUT : rrd_pkg::OP_HOLD;
			cmd.active = expire ? 1'b0 : active_q;
		end else begin
			cmd.op     = is_breath ? rrd_pkg::OP_BREATH : rrd_pkg::OP_HOLD;
			cmd.active = is_breath ? 1'b1 : active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			rise_q    <= '0;
			fall_q    <= '0;
			falling_q <= 1'b1;
			rising_q  <= 1'b0;
			ssb_q     <= '0;
			idle_q    <= '0;
			active_q  <= 1'b1;
		end else if (cmd_push) begin
			if (in.action == rrd_pkg::ACTION_TICK) begin
				idle_q <= expire ? '0 : idle_inc;
				if (expire) active_q <= 1'b0;
			end else begin
				prev_q <= in.sample;
				rise_q <= rise_nx;
				fall_q <= fall_nx;
				if (is_breath) begin
					falling_q <= 1'b0;
					rising_q  <= 1'b1;
					active_q  <= 1'b1;
					idle_q    <= '0;
					ssb_q     <= rrd_pkg::COUNT_BITS'(1);
				end else begin
					if (rearm) begin
						falling_q <= 1'b1;
						rising_q  <= 1'b0;
					end
					ssb_q <= ssb_inc;
				end
			end
		end
	end

endmodule

### sv/rrd_back.sv
`timescale 1ns / 1ps
module rrd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rrd_pkg::cfg_t cfg,
	input  rrd_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	rrd_out_if.source     out
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                       state_q;
	logic [rrd_pkg::RATE_BITS-1:0]    num_q, num_d, quo_q, rate_q;
	logic [rrd_pkg::COUNT_BITS-1:0]   n_q, rem_q, rem_nx;
	logic [rrd_pkg::COUNT_BITS:0]     rem_sh;
	logic                             rem_ge;
	logic [rrd_pkg::PROD_BITS-1:0]    prod_min_q, prod_max_q;
	logic [rrd_pkg::STEP_BITS-1:0]    cnt_q;
	logic                             alarm_q, event_q, active_q, out_valid_q;
	logic                             slot_free, need_div, load, div_alarm;

	assign slot_free = !out_valid_q || out.ready;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && slot_free;
	assign need_div  = (cmd.op == rrd_pkg::OP_BREATH) && (cmd.n != '0);
	assign load      = (cmd_pop && !need_div) || ((state_q == ST_DONE) && slot_free);

	assign num_d = (rrd_pkg::RATE_BITS'(cfg.sample_rate_hz) << 6)
		- (rrd_pkg::RATE_BITS'(cfg.sample_rate_hz) << 2);

	assign rem_sh = {rem_q, num_q[cnt_q]};
	assign rem_ge = (rem_sh >= {1'b0, n_q});
	assign rem_nx = rem_ge ? rrd_pkg::COUNT_BITS'(rem_sh - {1'b0, n_q})
		: rrd_pkg::COUNT_BITS'(rem_sh);

	assign div_alarm = (rrd_pkg::PROD_BITS'(num_q) < prod_min_q)
		|| (rrd_pkg::PROD_BITS'(num_q) > prod_max_q);

	assign out.valid            = out_valid_q;
	assign out.breath_event     = event_q;
	assign out.rate_bpm         = rate_q;
	assign out.rate_alarm       = alarm_q;
	assign out.breathing_active = active_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				num_q <= num_d;
				n_q   <= cmd.n;
			end
			ST_MUL: begin
				prod_min_q <= rrd_pkg::PROD_BITS'(cfg.breath_min) * rrd_pkg::PROD_BITS'(n_q);
				prod_max_q <= rrd_pkg::PROD_BITS'(cfg.breath_max) * rrd_pkg::PROD_BITS'(n_q);
				rem_q      <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[rrd_pkg::RATE_BITS-2:0], rem_ge};
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rate_q      <= '0;
			alarm_q     <= 1'b0;
			event_q     <= 1'b0;
			active_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (load)           out_valid_q <= 1'b1;
			else if (out.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						event_q  <= (cmd.op == rrd_pkg::OP_BREATH);
						active_q <= cmd.active;
						if (need_div) begin
							state_q <= ST_MUL;
						end else if (cmd.op == rrd_pkg::OP_BREATH) begin
							rate_q  <= '0;
							alarm_q <= 1'b1;
						end else if (cmd.op == rrd_pkg::OP_TIMEOUT) begin
							rate_q <= '0;
						end
					end
				end
				ST_MUL: begin
					cnt_q   <= rrd_pkg::STEP_BITS'(rrd_pkg::RATE_BITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						rate_q  <= quo_q;
						alarm_q <= div_alarm;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < n_q)
		else $error("divider remainder not below divisor");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> n_q != '0)
		else $error("divide started with zero sample count");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == '0 |=> state_q == ST_DONE)
		else $error("divider did not finish after last step");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_DIV) |-> !load)
		else $error("result loaded while divide in progress");
`endif

endmodule
